### src/srcu_pkg.sv
// Shared types and constants of the speed setpoint ramp command unit.
// No dependencies; imported by the register file, input stage, core and top level.
package srcu_pkg;

	localparam int STEP_W  = 10;
	localparam int LIMIT_W = 13;
	localparam int SP_W    = 14;
	localparam int WORD_W  = 32;
	localparam int SUM_W   = SP_W + 1;

	localparam logic [STEP_W-1:0]  RAMP_STEP_RST   = 10'd50;
	localparam logic [LIMIT_W-1:0] SPEED_LIMIT_RST = 13'd5000;

	typedef enum logic [3:0] {
		CMD_TICK      = 4'd0,
		CMD_TEST      = 4'd1,
		CMD_START     = 4'd2,
		CMD_TARGET    = 4'd3,
		CMD_SET_KP    = 4'd4,
		CMD_SET_KI    = 4'd5,
		CMD_SET_KD    = 4'd6,
		CMD_GET_PWM   = 4'd7,
		CMD_GET_ERR   = 4'd8,
		CMD_GET_KP    = 4'd9,
		CMD_GET_KI    = 4'd10,
		CMD_GET_KD    = 4'd11,
		CMD_GET_TGT   = 4'd12,
		CMD_GET_MEAS  = 4'd13,
		CMD_ECHO_A    = 4'd14,
		CMD_ECHO_B    = 4'd15
	} cmd_t;

	typedef enum logic {
		REG_RAMP_STEP   = 1'b0,
		REG_SPEED_LIMIT = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		RAMP_NONE = 2'd0,
		RAMP_UP   = 2'd1,
		RAMP_DOWN = 2'd2
	} ramp_t;

	typedef enum logic [1:0] {
		DIR_NONE = 2'd0,
		DIR_CW   = 2'd1,
		DIR_CCW  = 2'd2
	} dir_t;

	typedef struct packed {
		logic [STEP_W-1:0]  ramp_step;
		logic [LIMIT_W-1:0] speed_limit;
	} cfg_t;

	typedef struct packed {
		logic [3:0]               command;
		logic signed [WORD_W-1:0] value;
		logic signed [WORD_W-1:0] pwm_level;
		logic signed [WORD_W-1:0] pid_error;
		logic signed [WORD_W-1:0] measured_speed;
	} item_t;

endpackage

### src/srcu_cfg_regs.sv
// APB-style register file holding ramp_step and speed_limit.
// Depends on srcu_pkg.
module srcu_cfg_regs
	import srcu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output cfg_t        cfg
);

	logic [STEP_W-1:0]  ramp_step_q;
	logic [LIMIT_W-1:0] speed_limit_q;
	reg_idx_t           idx;
	logic               wr_en;

	assign pready = 1'b1;
	assign idx    = reg_idx_t'(paddr[2]);
	assign wr_en  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ramp_step_q   <= RAMP_STEP_RST;
			speed_limit_q <= SPEED_LIMIT_RST;
		end else if (wr_en) begin
			case (idx)
				REG_RAMP_STEP:   ramp_step_q   <= pwdata[STEP_W-1:0];
				REG_SPEED_LIMIT: speed_limit_q <= pwdata[LIMIT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_RAMP_STEP:   prdata = {{(32-STEP_W){1'b0}}, ramp_step_q};
			REG_SPEED_LIMIT: prdata = {{(32-LIMIT_W){1'b0}}, speed_limit_q};
			default:         prdata = '0;
		endcase
	end

	assign cfg.ramp_step   = ramp_step_q;
	assign cfg.speed_limit = speed_limit_q;

endmodule

### src/srcu_in_stage.sv
// Input register stage: captures one command transfer per cycle while s_tready is high.
// Depends on srcu_pkg.
module srcu_in_stage
	import srcu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,
	input  logic [3:0]   s_tuser,
	input  logic         take,
	output logic         valid_s1,
	output item_t        item_s1
);

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.command        <= s_tuser;
			item_s1.value          <= s_tdata[31:0];
			item_s1.pwm_level      <= s_tdata[63:32];
			item_s1.pid_error      <= s_tdata[95:64];
			item_s1.measured_speed <= s_tdata[127:96];
		end
	end

endmodule

### src/srcu_core.sv
// Command decode, ramp state and result register of the setpoint unit.
// Depends on srcu_pkg.
module srcu_core
	import srcu_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        in_valid,
	input  item_t       in_item,
	output logic        in_take,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,
	output logic        m_tuser
);

	logic signed [SP_W-1:0] setpoint_q, target_q;
	ramp_t                  ramp_q;
	dir_t                   dir_q;
	logic                   stop_pend_q, run_q;
	logic [WORD_W-1:0]      gain_q [3];

	logic signed [SP_W-1:0] setpoint_d, target_d;
	ramp_t                  ramp_d;
	dir_t                   dir_d;
	logic                   stop_pend_d, run_d;
	logic signed [WORD_W-1:0] reply_d;

	logic                   out_valid_s2;
	logic signed [WORD_W-1:0] reply_s2;
	logic                   is_reply_s2;
	logic signed [SP_W-1:0] setpoint_s2;
	logic                   running_s2;

	cmd_t                   cmd;
	logic signed [SUM_W-1:0] step_ext, sum, tgt_ext;
	logic                   done;
	logic signed [WORD_W:0] val_ext, lim_pos, lim_neg;
	logic signed [SP_W-1:0] clamped;

	assign in_take = in_valid && (!out_valid_s2 || m_tready);
	assign cmd     = cmd_t'(in_item.command);

	// ramp step toward the target
	always_comb begin
		step_ext = $signed({{(SUM_W-STEP_W){1'b0}}, cfg.ramp_step});
		tgt_ext  = SUM_W'(target_q);
		if (ramp_q == RAMP_UP) begin
			sum  = SUM_W'(setpoint_q) + step_ext;
			done = sum >= tgt_ext;
		end else begin
			sum  = SUM_W'(setpoint_q) - step_ext;
			done = sum <= tgt_ext;
		end
	end

	// target clamp to plus or minus the limit
	always_comb begin
		val_ext = {in_item.value[WORD_W-1], in_item.value};
		lim_pos = $signed({{(WORD_W+1-LIMIT_W){1'b0}}, cfg.speed_limit});
		lim_neg = -lim_pos;
		if (val_ext > lim_pos)
			clamped = SP_W'(lim_pos);
		else if (val_ext < lim_neg)
			clamped = SP_W'(lim_neg);
		else
			clamped = SP_W'(val_ext);
	end

	always_comb begin
		setpoint_d  = setpoint_q;
		target_d    = target_q;
		ramp_d      = ramp_q;
		dir_d       = dir_q;
		stop_pend_d = stop_pend_q;
		run_d       = run_q;
		reply_d     = in_item.value;
		case (cmd)
			CMD_TICK: begin
				reply_d = '0;
				if (run_q && ramp_q != RAMP_NONE) begin
					if (done) begin
						setpoint_d = target_q;
						ramp_d     = RAMP_NONE;
						if (stop_pend_q)
							run_d = 1'b0;
					end else begin
						setpoint_d = sum[SP_W-1:0];
					end
				end
			end
			CMD_START: begin
				if (in_item.value == '0) begin
					reply_d     = '0;
					stop_pend_d = 1'b1;
					target_d    = '0;
					ramp_d      = (dir_q == DIR_CW) ? RAMP_DOWN : RAMP_UP;
				end else begin
					run_d       = 1'b1;
					stop_pend_d = 1'b0;
				end
			end
			CMD_TARGET: begin
				reply_d  = WORD_W'(clamped);
				target_d = clamped;
				dir_d    = (clamped > 0) ? DIR_CW : DIR_CCW;
				if (clamped > setpoint_q)
					ramp_d = RAMP_UP;
				else if (clamped < setpoint_q)
					ramp_d = RAMP_DOWN;
			end
			CMD_GET_PWM:  reply_d = in_item.pwm_level;
			CMD_GET_ERR:  reply_d = in_item.pid_error;
			CMD_GET_KP:   reply_d = gain_q[0];
			CMD_GET_KI:   reply_d = gain_q[1];
			CMD_GET_KD:   reply_d = gain_q[2];
			CMD_GET_TGT:  reply_d = WORD_W'(target_q);
			CMD_GET_MEAS: reply_d = in_item.measured_speed;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setpoint_q  <= '0;
			target_q    <= '0;
			ramp_q      <= RAMP_NONE;
			dir_q       <= DIR_NONE;
			stop_pend_q <= 1'b0;
			run_q       <= 1'b0;
			gain_q[0]   <= '0;
			gain_q[1]   <= '0;
			gain_q[2]   <= '0;
		end else if (in_take) begin
			setpoint_q  <= setpoint_d;
			target_q    <= target_d;
			ramp_q      <= ramp_d;
			dir_q       <= dir_d;
			stop_pend_q <= stop_pend_d;
			run_q       <= run_d;
			case (cmd)
				CMD_SET_KP: gain_q[0] <= in_item.value;
				CMD_SET_KI: gain_q[1] <= in_item.value;
				CMD_SET_KD: gain_q[2] <= in_item.value;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (!out_valid_s2 || m_tready) begin
			out_valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			reply_s2    <= reply_d;
			is_reply_s2 <= (cmd != CMD_TICK);
			setpoint_s2 <= setpoint_d;
			running_s2  <= run_d;
		end
	end

	// a test write only echoes its value; the word is never read back
	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {1'b0, running_s2, setpoint_s2, reply_s2};
	assign m_tuser  = is_reply_s2;

endmodule

### src/speed_setpoint_ramp_command_unit.sv
// Top level of the speed setpoint ramp command unit.
// Depends on srcu_pkg, srcu_cfg_regs, srcu_in_stage and srcu_core.
//
//  channel  | direction | handshake        | payload
//  ---------+-----------+------------------+----------------------------------------
//  s_*      | in        | s_tvalid/s_tready| tuser command, tdata value..measured
//  m_*      | out       | m_tvalid/m_tready| tuser is_reply, tdata reply/setpoint/run
//  APB      | in        | psel/penable     | ramp_step @0x0, speed_limit @0x4
//
// Each command passes through the input register, then through decode and ramp
// logic into the result register. A new command transfers every cycle while
// the result is not stalled; the ramp state updates as a command enters the
// result register, so consecutive commands see each other's effects in order.
// Reset clears the ramp state, gains and both valid flags and loads
// ramp_step 50 and speed_limit 5000. When m_tready drops, the result holds and
// s_tready falls once the input register holds a command.
module speed_setpoint_ramp_command_unit
	import srcu_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// bits: value[31:0], pwm_level[63:32], pid_error[95:64], measured_speed[127:96]
	input  logic [127:0] s_tdata,
	// bits: command[3:0]
	input  logic [3:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// bits: reply_value[31:0], setpoint[45:32], running[46], zero[47]
	output logic [47:0]  m_tdata,
	// bits: is_reply[0]
	output logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	cfg_t  cfg;
	logic  take;
	logic  valid_s1;
	item_t item_s1;

	// configuration registers, to be written only while idle; the block does not enforce this
	srcu_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// capture the command transfer
	srcu_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	// decode, advance the ramp, register the result
	srcu_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (valid_s1),
		.in_item  (item_s1),
		.in_take  (take),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

### src/srcu_checker.sv
// Port-level checks for the speed setpoint ramp command unit, bound to the top.
// Depends only on the top level's ports.
module srcu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [47:0] m_tdata,
	input logic        m_tuser,
	input logic        pready
);

	// a stalled result stays presented
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	// a tick answers with a zero reply word
	a_tick_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[31:0] == 32'd0)
		else $error("tick result carries nonzero reply");

	// the setpoint never reaches the most negative code
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[45:32] != 14'h2000)
		else $error("setpoint out of range");

	// with a stalled result and a full input register, input stays refused until m_tready rises
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready && !s_tready |=> !s_tready || m_tready)
		else $error("input accepted while both stages are full");

	a_pready: assert property (@(posedge clk) pready)
		else $error("pready low");

endmodule

bind speed_setpoint_ramp_command_unit srcu_checker u_srcu_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.pready   (pready)
);
